// File: hw/rtl/websocket_frame_deframer_macros.svh
// Assertion helpers used by the deframer top module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wsfd_pkg.sv
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_TEXT   = 3'd1,
    KIND_OTHER  = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_t;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef struct packed {
    logic       nul_in_text;
    logic       unknown_opcode;
    logic       close_request;
    logic       final_fragment;
    logic [3:0] frame_opcode;
    logic       last;
    kind_t      kind;
    logic [7:0] out_byte;
  } res_t;

  function automatic logic opcode_known(input logic [3:0] op);
    logic known;
    case (op) inside
      OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

// File: hw/rtl/wsfd_parser.sv
module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  logic              require_mask,
  output wsfd_pkg::res_t    res
);

  wsfd_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [3:0]  len_left_r, len_left_nxt;
  logic [63:0] pay_left_r, pay_left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_left_r, key_left_nxt;
  logic [1:0]  key_pos_r, key_pos_nxt;
  logic        masked_r, masked_nxt;

  logic [6:0]  len7;
  logic        mbit;
  logic        mask_err;
  logic [3:0]  len_left_dec;
  logic [2:0]  key_left_dec;
  logic [63:0] pay_left_dec;
  logic [63:0] pay_shift;
  logic        ext_done;
  logic        key_done;
  logic        pay_done;
  logic        pay_zero;
  logic [7:0]  key_byte;
  logic [7:0]  plain;

  assign len7         = rx_byte[6:0];
  assign mbit         = rx_byte[7];
  assign mask_err     = !mbit && require_mask;
  assign len_left_dec = len_left_r - 4'd1;
  assign key_left_dec = key_left_r - 3'd1;
  assign pay_left_dec = pay_left_r - 64'd1;
  assign pay_shift    = {pay_left_r[55:0], rx_byte};
  assign ext_done     = (len_left_dec == 4'd0);
  assign key_done     = (key_left_dec == 3'd0);
  assign pay_done     = (pay_left_dec == 64'd0);
  assign pay_zero     = (pay_left_r == 64'd0);
  // first key byte received sits in the top lane
  assign key_byte     = masked_r ? key_r[{~key_pos_r, 3'b000} +: 8] : 8'd0;
  assign plain        = rx_byte ^ key_byte;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (frame_start) begin
      phase_nxt = wsfd_pkg::PH_LEN;
    end else begin
      unique case (phase_r)
        wsfd_pkg::PH_IDLE: phase_nxt = wsfd_pkg::PH_IDLE;
        wsfd_pkg::PH_LEN: begin
          if (mask_err) begin
            phase_nxt = wsfd_pkg::PH_IDLE;
          end else if (len7 == wsfd_pkg::LEN_EXT16 || len7 == wsfd_pkg::LEN_EXT64) begin
            phase_nxt = wsfd_pkg::PH_EXTLEN;
          end else if (mbit) begin
            phase_nxt = wsfd_pkg::PH_KEY;
          end else begin
            phase_nxt = (len7 == 7'd0) ? wsfd_pkg::PH_IDLE : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          if (ext_done) begin
            if (masked_r) begin
              phase_nxt = wsfd_pkg::PH_KEY;
            end else begin
              phase_nxt = (pay_shift == 64'd0) ? wsfd_pkg::PH_IDLE : wsfd_pkg::PH_PAYLOAD;
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          if (key_done) begin
            phase_nxt = pay_zero ? wsfd_pkg::PH_IDLE : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          if (pay_done) begin
            phase_nxt = wsfd_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = wsfd_pkg::PH_IDLE;
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    res                = '0;
    res.kind           = wsfd_pkg::KIND_HEADER;
    res.frame_opcode   = opcode_nxt;
    res.final_fragment = fin_nxt;
    res.unknown_opcode = !wsfd_pkg::opcode_known(opcode_nxt);
    if (!frame_start) begin
      unique case (phase_r)
        wsfd_pkg::PH_IDLE: res.kind = wsfd_pkg::KIND_IGNORE;
        wsfd_pkg::PH_LEN: begin
          if (mask_err) begin
            res.kind = wsfd_pkg::KIND_ERROR;
            res.last = 1'b1;
          end else if (!mbit && len7 != wsfd_pkg::LEN_EXT16
                       && len7 != wsfd_pkg::LEN_EXT64) begin
            res.close_request = (opcode_r == wsfd_pkg::OP_CLOSE);
            res.last          = (len7 == 7'd0);
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          if (ext_done && !masked_r) begin
            res.close_request = (opcode_r == wsfd_pkg::OP_CLOSE);
            res.last          = (pay_shift == 64'd0);
          end
        end
        wsfd_pkg::PH_KEY: begin
          if (key_done) begin
            res.close_request = (opcode_r == wsfd_pkg::OP_CLOSE);
            res.last          = pay_zero;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          res.out_byte = plain;
          res.last     = pay_done;
          if (opcode_r == wsfd_pkg::OP_TEXT) begin
            res.kind        = wsfd_pkg::KIND_TEXT;
            res.nul_in_text = (plain == 8'd0);
          end else begin
            res.kind = wsfd_pkg::KIND_OTHER;
          end
        end
        default: res.kind = wsfd_pkg::KIND_IGNORE;
      endcase
    end
  end

  // frame context, length and key
  always_comb begin
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    len_left_nxt = len_left_r;
    pay_left_nxt = pay_left_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    key_pos_nxt  = key_pos_r;
    masked_nxt   = masked_r;
    if (frame_start) begin
      fin_nxt      = rx_byte[7];
      opcode_nxt   = rx_byte[3:0];
      len_left_nxt = 4'd0;
      pay_left_nxt = 64'd0;
      key_nxt      = 32'd0;
      key_left_nxt = 3'd0;
      key_pos_nxt  = 2'd0;
      masked_nxt   = 1'b0;
    end else begin
      case (phase_r)
        wsfd_pkg::PH_LEN: begin
          masked_nxt = mbit;
          if (!mask_err) begin
            if (len7 == wsfd_pkg::LEN_EXT16) begin
              len_left_nxt = wsfd_pkg::EXT16_BYTES;
            end else if (len7 == wsfd_pkg::LEN_EXT64) begin
              len_left_nxt = wsfd_pkg::EXT64_BYTES;
            end else begin
              pay_left_nxt = {57'd0, len7};
              key_nxt      = 32'd0;
              if (mbit) begin
                key_left_nxt = wsfd_pkg::KEY_BYTES;
              end else begin
                key_pos_nxt = 2'd0;
              end
            end
          end
        end
        wsfd_pkg::PH_EXTLEN: begin
          pay_left_nxt = pay_shift;
          len_left_nxt = len_left_dec;
          if (ext_done) begin
            key_nxt = 32'd0;
            if (masked_r) begin
              key_left_nxt = wsfd_pkg::KEY_BYTES;
            end else begin
              key_pos_nxt = 2'd0;
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          key_nxt      = {key_r[23:0], rx_byte};
          key_left_nxt = key_left_dec;
          if (key_done) begin
            key_pos_nxt = 2'd0;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          key_pos_nxt  = key_pos_r + 2'd1;
          pay_left_nxt = pay_left_dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsfd_pkg::PH_IDLE;
      fin_r      <= 1'b0;
      opcode_r   <= 4'd0;
      len_left_r <= 4'd0;
      key_left_r <= 3'd0;
      key_pos_r  <= 2'd0;
      masked_r   <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      len_left_r <= len_left_nxt;
      key_left_r <= key_left_nxt;
      key_pos_r  <= key_pos_nxt;
      masked_r   <= masked_nxt;
    end
  end

  // length count and key are always reloaded by a frame start before use
  always_ff @(posedge clk) begin
    if (step_en) begin
      pay_left_r <= pay_left_nxt;
      key_r      <= key_nxt;
    end
  end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// WebSocket receive deframer: one frame byte in, one tagged result item out.
// Input channel in_*: in_tdata carries the received byte, in_tuser marks the
// first byte of a frame. A start mark always opens a new frame and drops any
// frame in progress without a last mark.
// Result channel out_*: out_tuser gives the kind (header, text, other payload,
// unmasked error, ignored), out_tlast marks the final byte of a frame, and
// out_tdata carries the unmasked byte plus the frame context flags.
// Config: cfg_wen/cfg_wdata write require_mask; write it only while idle.
// Timing: an accepted item is held in the input register, parsed out of it, and
// its result is registered in the output register, which drives out_tvalid.
// One item per cycle is sustained while out_tready is high; the limit is
// the single parse step on the input register that updates the frame state.
// Stall: with out_tready low the output register holds its result, the input
// register holds one more item, and then in_tready drops.
// Reset (rst_n low, synchronous): both stages empty, in_tready low, parser
// waits for a frame start, opcode and FIN read as zero, require_mask set.
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [11:8] frame_opcode,
                                  // [12] final_fragment, [13] close_request,
                                  // [14] unknown_opcode, [15] nul_in_text
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,  // last byte of the frame
  // configuration
  input  logic        cfg_wen,
  input  logic        cfg_wdata   // require_mask
);

  logic           require_mask_r;
  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic           s1_start_r;
  logic           s1_adv;
  logic           in_accept;
  logic           out_valid_r;
  wsfd_pkg::res_t res;
  wsfd_pkg::res_t out_r;

  // advance the input register whenever the output register is free or draining
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || s1_adv);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      require_mask_r <= 1'b1;
    end else if (cfg_wen) begin
      require_mask_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  wsfd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .rx_byte      (s1_byte_r),
    .frame_start  (s1_start_r),
    .require_mask (require_mask_r),
    .res          (res)
  );

  // output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.nul_in_text, out_r.unknown_opcode, out_r.close_request,
                       out_r.final_fragment, out_r.frame_opcode, out_r.out_byte};

  `WSFD_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready, !in_tready,
    "input ready while both stages were full and stalled")
  `WSFD_ASSERT_NOW(a_ignored_is_empty, clk, rst_n,
    out_valid_r && out_r.kind == wsfd_pkg::KIND_IGNORE,
    out_r.out_byte == 8'd0 && !out_r.last && !out_r.close_request,
    "ignored item carries data, last or close")
  `WSFD_ASSERT_NOW(a_close_on_header, clk, rst_n,
    out_valid_r && out_r.close_request,
    out_r.kind == wsfd_pkg::KIND_HEADER && out_r.frame_opcode == wsfd_pkg::OP_CLOSE,
    "close request outside a close frame header")
  `WSFD_ASSERT_NOW(a_nul_only_in_text, clk, rst_n,
    out_valid_r && out_r.nul_in_text,
    out_r.kind == wsfd_pkg::KIND_TEXT && out_r.out_byte == 8'd0,
    "zero-byte flag on a non-text or nonzero item")

endmodule
